// ----- sv/stb_pkg.sv -----
// Shared types, command codes and helpers for the software timer bank.
// Used by stb_front, stb_back and software_timer_bank_top; depends on nothing.
package stb_pkg;

    // Number of timer channels and the width of a channel index in the bank.
    localparam int CHANNELS = 16;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Depth of the command queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QP_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QC_W   = $clog2(QDEPTH + 1);

    // Field widths fixed by the command word.
    localparam int CMD_W    = 3;
    localparam int CHAN_W   = 4;
    localparam int TGT_W    = 32;
    localparam int NOW_W    = 16;
    localparam int MASK_W   = 16;
    localparam int WRAP_MAX = 16'hFFFF;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INIT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRAP  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CHECK = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd5;

    // Classes the front assigns to each command.
    localparam logic [1:0] KIND_REPORT = 2'd0;
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_SCAN   = 2'd2;

    // One classified command as it travels through the queue.
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [CHAN_W-1:0] channel;
        logic [TGT_W-1:0]  target_us;
        logic [NOW_W-1:0]  now_us;
        logic              ch_ok;
        logic [1:0]        kind;
    } stb_item_t;

    // Elapsed time of one channel: wraps * 65536 + now - stamp, floored at zero.
    // The largest possible value is exactly 32'hFFFFFFFF, so no upper clamp is needed.
    function automatic logic [31:0] elapsed_of(input logic [15:0] wraps,
                                               input logic [15:0] now,
                                               input logic [15:0] stamp);
        logic [31:0] whole;
        logic [31:0] base;
        whole = {wraps, now};
        base  = {16'd0, stamp};
        return (whole < base) ? 32'd0 : (whole - base);
    endfunction

endpackage

// ----- sv/software_timer_bank_top.sv -----
// Top level of the software timer bank: joins the command front end to the
// executing back end. Depends on stb_pkg, stb_front and stb_back.
//
//  Channel   Handshake            Word fields
//  -------   ------------------   ------------------------------------------------
//  command   start / busy         command, channel, target_us, now_us
//  result    done (one cycle)     running, expired, elapsed_us, expired_mask
//
// A command word is taken at a rising edge with start high and busy low. The
// front end classifies it and places it in a two-word queue; busy is high only
// while that queue is full. The back end runs one word at a time against the
// per-channel state: init, start and stop on a valid channel take a write
// step before the report step, read goes straight to it, and wrap and check
// sweep each channel through a single state read port, in a read and a write step.
// Each result word is shown for exactly one cycle with done high; the
// receiver cannot stall it, so results never back up into the queue.
// Reset is asynchronous and active low, and clears all channels to stopped,
// not expired, with zero stamp, wrap count and target.
module software_timer_bank_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [stb_pkg::CMD_W-1:0]     command,
    input  logic [stb_pkg::CHAN_W-1:0]    channel,
    input  logic [stb_pkg::TGT_W-1:0]     target_us,
    input  logic [stb_pkg::NOW_W-1:0]     now_us,
    output logic                          done,
    output logic                          running,
    output logic                          expired,
    output logic [31:0]                   elapsed_us,
    output logic [stb_pkg::MASK_W-1:0]    expired_mask
);

    // Queue interface between the two halves.
    logic                 q_valid;
    logic                 q_pop;
    stb_pkg::stb_item_t   q_item;

    stb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .channel   (channel),
        .target_us (target_us),
        .now_us    (now_us),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    stb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .done         (done),
        .running      (running),
        .expired      (expired),
        .elapsed_us   (elapsed_us),
        .expired_mask (expired_mask)
    );

endmodule

// ----- sv/stb_front.sv -----
// Front end of the timer bank: accepts command words, classifies them and
// queues them for the back end. Depends on stb_pkg.
module stb_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [stb_pkg::CMD_W-1:0]     command,
    input  logic [stb_pkg::CHAN_W-1:0]    channel,
    input  logic [stb_pkg::TGT_W-1:0]     target_us,
    input  logic [stb_pkg::NOW_W-1:0]     now_us,
    output logic                          q_valid,
    output stb_pkg::stb_item_t            q_item,
    input  logic                          q_pop
);

    stb_pkg::stb_item_t             item_in;
    stb_pkg::stb_item_t             q_mem_reg [stb_pkg::QDEPTH];
    logic [stb_pkg::QP_W-1:0]       wr_ptr_reg;
    logic [stb_pkg::QP_W-1:0]       wr_ptr_next;
    logic [stb_pkg::QP_W-1:0]       rd_ptr_reg;
    logic [stb_pkg::QP_W-1:0]       rd_ptr_next;
    logic [stb_pkg::QC_W-1:0]       count_reg;
    logic [stb_pkg::QC_W-1:0]       count_next;
    logic                           push;
    logic                           pop;
    logic                           ch_ok;

    // Classification: which commands touch one entry, which sweep the bank.
    assign ch_ok = (32'(channel) < 32'(stb_pkg::CHANNELS));

    always_comb
    begin
        item_in.command   = command;
        item_in.channel   = channel;
        item_in.target_us = target_us;
        item_in.now_us    = now_us;
        item_in.ch_ok     = ch_ok;
        unique case (command) inside
            stb_pkg::CMD_INIT, stb_pkg::CMD_START, stb_pkg::CMD_STOP:
            begin
                item_in.kind = ch_ok ? stb_pkg::KIND_WRITE : stb_pkg::KIND_REPORT;
            end
            stb_pkg::CMD_WRAP, stb_pkg::CMD_CHECK:
            begin
                item_in.kind = stb_pkg::KIND_SCAN;
            end
            default:
            begin
                item_in.kind = stb_pkg::KIND_REPORT;
            end
        endcase
    end

    assign busy    = (count_reg == stb_pkg::QC_W'(stb_pkg::QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = q_mem_reg[rd_ptr_reg];
    assign push    = start && !busy;
    assign pop     = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == stb_pkg::QP_W'(stb_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == stb_pkg::QP_W'(stb_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= item_in;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= stb_pkg::QC_W'(stb_pkg::QDEPTH))
        else $error("command queue holds more words than its depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("command queue lost a pushed word");

endmodule

// ----- sv/stb_back.sv -----
// Back end of the timer bank: holds the channel state, executes queued
// commands one at a time and registers the result word. Depends on stb_pkg.
module stb_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  stb_pkg::stb_item_t           q_item,
    output logic                         q_pop,
    output logic                         done,
    output logic                         running,
    output logic                         expired,
    output logic [31:0]                  elapsed_us,
    output logic [stb_pkg::MASK_W-1:0]   expired_mask
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_WRITE   = 3'd1;
    localparam logic [2:0] S_SCAN_RD = 3'd2;
    localparam logic [2:0] S_SCAN_WR = 3'd3;
    localparam logic [2:0] S_REPORT  = 3'd4;

    logic [2:0]                    state_reg;
    logic [2:0]                    state_next;
    logic [stb_pkg::CH_W-1:0]      idx_reg;
    logic [stb_pkg::CH_W-1:0]      idx_next;
    stb_pkg::stb_item_t            item_reg;
    stb_pkg::stb_item_t            item_next;
    logic [31:0]                   scan_el_reg;
    logic [31:0]                   scan_el_next;
    logic [stb_pkg::MASK_W-1:0]    mask_reg;
    logic [stb_pkg::MASK_W-1:0]    mask_next;
    logic                          done_reg;
    logic                          done_next;
    logic                          running_reg;
    logic                          running_next;
    logic                          expired_reg;
    logic                          expired_next;
    logic [31:0]                   elapsed_reg;
    logic [31:0]                   elapsed_next;
    logic [stb_pkg::MASK_W-1:0]    mask_out_reg;
    logic [stb_pkg::MASK_W-1:0]    mask_out_next;

    // Channel state, one entry per channel.
    logic                          run_reg    [stb_pkg::CHANNELS];
    logic                          exp_reg    [stb_pkg::CHANNELS];
    logic [15:0]                   stamp_reg  [stb_pkg::CHANNELS];
    logic [15:0]                   wrap_reg   [stb_pkg::CHANNELS];
    logic [31:0]                   target_reg [stb_pkg::CHANNELS];

    logic [stb_pkg::CH_W-1:0]      rd_addr;
    logic                          rd_run;
    logic                          rd_exp;
    logic [15:0]                   rd_wrap;
    logic [31:0]                   rd_target;
    logic [31:0]                   rd_elapsed;
    logic                          in_scan;
    logic                          is_last;
    logic                          hit;

    // A single read port: the sweep index during a scan, the addressed channel otherwise.
    assign in_scan    = (state_reg == S_SCAN_RD) || (state_reg == S_SCAN_WR);
    assign rd_addr    = in_scan ? idx_reg : stb_pkg::CH_W'(item_reg.channel);
    assign rd_run     = run_reg[rd_addr];
    assign rd_exp     = exp_reg[rd_addr];
    assign rd_wrap    = wrap_reg[rd_addr];
    assign rd_target  = target_reg[rd_addr];
    assign rd_elapsed = stb_pkg::elapsed_of(rd_wrap, item_reg.now_us, stamp_reg[rd_addr]);
    assign is_last    = (idx_reg == stb_pkg::CH_W'(stb_pkg::CHANNELS - 1));
    assign hit        = rd_run && (scan_el_reg > rd_target);

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        item_next     = item_reg;
        scan_el_next  = scan_el_reg;
        mask_next     = mask_reg;
        done_next     = 1'b0;
        running_next  = running_reg;
        expired_next  = expired_reg;
        elapsed_next  = elapsed_reg;
        mask_out_next = mask_out_reg;
        q_pop         = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    mask_next = '0;
                    idx_next  = '0;
                    unique case (q_item.kind)
                        stb_pkg::KIND_WRITE: state_next = S_WRITE;
                        stb_pkg::KIND_SCAN:  state_next = S_SCAN_RD;
                        default:             state_next = S_REPORT;
                    endcase
                end
            end
            S_WRITE:
            begin
                state_next = S_REPORT;
            end
            S_SCAN_RD:
            begin
                scan_el_next = rd_elapsed;
                state_next   = S_SCAN_WR;
            end
            S_SCAN_WR:
            begin
                if ((item_reg.command == stb_pkg::CMD_CHECK) && hit &&
                    (32'(idx_reg) < 32'(stb_pkg::MASK_W)))
                begin
                    mask_next = mask_reg | (stb_pkg::MASK_W'(1) << idx_reg);
                end
                if (is_last)
                begin
                    idx_next   = '0;
                    state_next = S_REPORT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_REPORT:
            begin
                done_next     = 1'b1;
                running_next  = item_reg.ch_ok && rd_run;
                expired_next  = item_reg.ch_ok && rd_exp;
                elapsed_next  = item_reg.ch_ok ? rd_elapsed : 32'd0;
                mask_out_next = mask_reg;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        scan_el_reg  <= scan_el_next;
        mask_reg     <= mask_next;
        running_reg  <= running_next;
        expired_reg  <= expired_next;
        elapsed_reg  <= elapsed_next;
        mask_out_reg <= mask_out_next;
    end

    // Channel state updates: single-entry writes and the per-channel step of a sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < stb_pkg::CHANNELS; i++)
            begin
                run_reg[i]    <= 1'b0;
                exp_reg[i]    <= 1'b0;
                stamp_reg[i]  <= '0;
                wrap_reg[i]   <= '0;
                target_reg[i] <= '0;
            end
        end
        else if (state_reg == S_WRITE)
        begin
            unique case (item_reg.command)
                stb_pkg::CMD_INIT:
                begin
                    target_reg[rd_addr] <= item_reg.target_us;
                    wrap_reg[rd_addr]   <= '0;
                    exp_reg[rd_addr]    <= 1'b0;
                end
                stb_pkg::CMD_START:
                begin
                    run_reg[rd_addr]   <= 1'b1;
                    stamp_reg[rd_addr] <= item_reg.now_us;
                end
                stb_pkg::CMD_STOP:
                begin
                    run_reg[rd_addr] <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        else if (state_reg == S_SCAN_WR)
        begin
            if (item_reg.command == stb_pkg::CMD_WRAP)
            begin
                if (rd_run && (rd_wrap != 16'(stb_pkg::WRAP_MAX)))
                begin
                    wrap_reg[rd_addr] <= rd_wrap + 16'd1;
                end
            end
            else if (rd_run)
            begin
                if (hit)
                begin
                    exp_reg[rd_addr] <= 1'b1;
                    run_reg[rd_addr] <= 1'b0;
                end
                else
                begin
                    exp_reg[rd_addr] <= 1'b0;
                end
            end
        end
    end

    assign done         = done_reg;
    assign running      = running_reg;
    assign expired      = expired_reg;
    assign elapsed_us   = elapsed_reg;
    assign expired_mask = mask_out_reg;

    a_done_from_report: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == S_REPORT))
        else $error("result strobe without a report step");

    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_scan |-> (idx_reg == '0))
        else $error("sweep index left nonzero outside a sweep");

    a_mask_only_check: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (mask_out_reg != '0)) |-> (item_reg.command == stb_pkg::CMD_CHECK))
        else $error("expired mask set by a command other than check");

    a_bad_channel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !item_reg.ch_ok) |-> (!running_reg && !expired_reg &&
                                            (elapsed_reg == 32'd0)))
        else $error("result for an absent channel is not zero");

endmodule
